// ===== design/four_encoder_outlier_average_unit_macros.svh =====
// Assertion helpers for the outlier average block.
// All checks run on clk and are switched off while rst is high.
`ifndef FOUR_ENCODER_OUTLIER_AVERAGE_UNIT_MACROS_SVH
`define FOUR_ENCODER_OUTLIER_AVERAGE_UNIT_MACROS_SVH

// same-cycle implication
`define FOA_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define FOA_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/foa_pkg.sv =====
package foa_pkg;

  // encoder count and field widths
  localparam int ENC_COUNT   = 4;
  localparam int POS_W       = 32;
  localparam int DIST_W      = 32;
  localparam int SUM_W       = 34;
  localparam int VOTE_W      = SUM_W + 2;
  localparam int AVG_W       = 40;
  localparam int CFG_INDEX_W = 8;
  localparam int KEPT_N_W    = 3;

  // divide-by-three pipeline: base-256 long division, two digits a stage
  localparam int DIG_W        = 8;
  localparam int DIV_W        = 40;
  localparam int STAGE_DIGITS = 2;
  localparam int DIV3_SHIFT   = 11;
  localparam logic [DIG_W+1:0] DIV3_RECIP = 10'd683;

  // voting thresholds; the totals are scaled to the sum of four distances
  localparam logic [DIST_W-1:0] STALL_DIST   = 32'd10;
  localparam logic [SUM_W-1:0]  STALL_TOTAL  = 34'd400;
  localparam logic [SUM_W-1:0]  SUBSET_TOTAL = 34'd1200;
  localparam logic [KEPT_N_W-1:0] SUBSET_MIN = 3'd2;
  localparam logic [KEPT_N_W-1:0] SUBSET_MAX = 3'd3;

  // configuration register indexes
  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_BASE_FL = 8'd0,
    REG_BASE_FR = 8'd1,
    REG_BASE_RL = 8'd2,
    REG_BASE_RR = 8'd3
  } cfg_reg_t;

  typedef logic signed [POS_W-1:0] pos_t;
  typedef logic [DIST_W-1:0]       dist_t;
  typedef logic [SUM_W-1:0]        sum_t;

  // result of one divide stage
  typedef struct packed {
    logic [STAGE_DIGITS*DIG_W-1:0] quo;
    logic [1:0]                    rem;
  } div3_part_t;

endpackage

// ===== design/foa_dist_lane.sv =====
module foa_dist_lane
  import foa_pkg::*;
(
  input  pos_t  pos,
  input  pos_t  base,
  output dist_t travel
);

  logic signed [POS_W:0] diff;
  logic signed [POS_W:0] mag;

  // 33-bit difference, so the magnitude always fits 32 bits
  always_comb begin
    diff   = {pos[POS_W-1], pos} - {base[POS_W-1], base};
    mag    = diff[POS_W] ? -diff : diff;
    travel = mag[DIST_W-1:0];
  end

endmodule

// ===== design/foa_vote_lane.sv =====
module foa_vote_lane
  import foa_pkg::*;
(
  input  dist_t travel,
  input  sum_t  total,
  output logic  keep
);

  logic [VOTE_W-1:0] d8;
  logic [VOTE_W-1:0] total1;
  logic [VOTE_W-1:0] total3;
  logic              out_low;
  logic              out_high;
  logic              stuck;

  // 8*d against S and 3*S; a near-still wheel is dropped when the rest moved
  always_comb begin
    d8       = VOTE_W'({travel, 3'b000});
    total1   = VOTE_W'(total);
    total3   = total1 + VOTE_W'({total, 1'b0});
    out_low  = d8 < total1;
    out_high = d8 > total3;
    stuck    = (travel < STALL_DIST) && (total > STALL_TOTAL);
    keep     = !(out_low || out_high || stuck);
  end

endmodule

// ===== design/foa_div3_stage.sv =====
module foa_div3_stage
  import foa_pkg::*;
#(
  parameter int NDIG = STAGE_DIGITS
)
(
  input  logic [1:0]            rem_in,
  input  logic [NDIG*DIG_W-1:0] digits,
  output logic [NDIG*DIG_W-1:0] quo,
  output logic [1:0]            rem_out
);

  localparam int V_W    = DIG_W + 2;
  localparam int PROD_W = 2 * V_W;

  logic [1:0]        rem;
  logic [V_W-1:0]    v;
  logic [PROD_W-1:0] prod;
  logic [DIG_W-1:0]  qd;
  logic [V_W-1:0]    q3;
  logic [V_W-1:0]    rem_full;

  // one base-256 digit per step, most significant first; v/3 by reciprocal
  always_comb begin
    rem      = rem_in;
    v        = '0;
    prod     = '0;
    qd       = '0;
    q3       = '0;
    rem_full = '0;
    quo      = '0;
    for (int i = NDIG - 1; i >= 0; i--) begin
      v        = {rem, digits[i*DIG_W +: DIG_W]};
      prod     = PROD_W'(v) * PROD_W'(DIV3_RECIP);
      qd       = prod[DIV3_SHIFT +: DIG_W];
      q3       = V_W'(qd) + V_W'({qd, 1'b0});
      rem_full = v - q3;
      quo[i*DIG_W +: DIG_W] = qd;
      rem      = rem_full[1:0];
    end
    rem_out = rem;
  end

endmodule

// ===== design/four_encoder_outlier_average_unit.sv =====
// Throughput: one item per cycle unless out_stall holds the pipeline; seven register stages (distance,
// sum, vote, merge, two divide-by-three stages, output) each take a new item every cycle they advance.
// A stalled output lets earlier stages fill their empty slots before in_stall rises.
// Reset: stage valid bits cleared, all four baselines set to zero.
module four_encoder_outlier_average_unit
  import foa_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  // input items
  input  logic                   in_valid,
  output logic                   in_stall,
  input  pos_t                   pos_front_left,
  input  pos_t                   pos_front_right,
  input  pos_t                   pos_rear_left,
  input  pos_t                   pos_rear_right,
  // result items
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [AVG_W-1:0]       distance_avg_q8,
  output logic [3:0]             kept_mask,
  output logic                   used_subset,
  // configuration writes
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [POS_W-1:0]       cfg_data
);

`include "four_encoder_outlier_average_unit_macros.svh"

  localparam int STAGES  = 7;
  localparam int PART_W  = STAGE_DIGITS * DIG_W;
  localparam int QUO_W   = AVG_W - DIG_W;

  pos_t baseline [ENC_COUNT];
  pos_t pos_in   [ENC_COUNT];
  dist_t lane_dist [ENC_COUNT];
  logic [ENC_COUNT-1:0] lane_keep;

  logic [STAGES:1] vld;
  logic [STAGES:1] adv;

  dist_t s1_dist [ENC_COUNT];
  dist_t s2_dist [ENC_COUNT];
  sum_t  s2_total;
  dist_t s3_dist [ENC_COUNT];
  sum_t  s3_total;
  logic [ENC_COUNT-1:0] s3_mask;
  sum_t  s4_total, s5_total, s6_total;
  sum_t  s4_ksum, s5_ksum, s6_ksum;
  logic [ENC_COUNT-1:0] s4_mask, s5_mask, s6_mask;
  logic  s4_subset, s5_subset, s6_subset;
  logic  s4_three, s5_three, s6_three;
  logic [PART_W-1:0] s5_q_hi, s6_q_hi, s6_q_mid;
  logic [1:0] s5_rem, s6_rem;

  sum_t total_next;
  sum_t ksum_next;
  logic [KEPT_N_W-1:0] kept_n;
  logic subset_next;
  logic three_next;
  logic [DIV_W-1:0] num4, num5;
  div3_part_t part_a, part_b;
  logic [DIG_W-1:0] quo_lo;
  logic [1:0] rem_lo;
  logic [DIV_W-1:0] quo_all;
  logic [DIG_W-1:0] frac;
  logic [AVG_W-1:0] avg_next;

  // configuration port, always ready; unknown indexes are dropped
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < ENC_COUNT; i++) begin
        baseline[i] <= '0;
      end
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_BASE_FL: baseline[0] <= cfg_data;
        REG_BASE_FR: baseline[1] <= cfg_data;
        REG_BASE_RL: baseline[2] <= cfg_data;
        REG_BASE_RR: baseline[3] <= cfg_data;
        default: ;
      endcase
    end
  end

  // stage enables: a stage moves when it is empty or the next one moves
  always_comb begin
    adv[STAGES] = !vld[STAGES] || !out_stall;
    for (int k = STAGES - 1; k >= 1; k--) begin
      adv[k] = !vld[k] || adv[k+1];
    end
  end

  assign in_stall  = !adv[1];
  assign out_valid = vld[STAGES];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (adv[1]) begin
        vld[1] <= in_valid;
      end
      for (int k = 2; k <= STAGES; k++) begin
        if (adv[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  // distance lanes
  assign pos_in[0] = pos_front_left;
  assign pos_in[1] = pos_front_right;
  assign pos_in[2] = pos_rear_left;
  assign pos_in[3] = pos_rear_right;

  for (genvar g = 0; g < ENC_COUNT; g++) begin : g_dist
    foa_dist_lane u_dist (
      .pos    (pos_in[g]),
      .base   (baseline[g]),
      .travel (lane_dist[g])
    );
  end

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      s1_dist <= lane_dist;
    end
  end

  // sum of all four distances
  always_comb begin
    total_next = '0;
    for (int i = 0; i < ENC_COUNT; i++) begin
      total_next = total_next + SUM_W'(s1_dist[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (adv[2]) begin
      s2_dist  <= s1_dist;
      s2_total <= total_next;
    end
  end

  // vote lanes
  for (genvar g = 0; g < ENC_COUNT; g++) begin : g_vote
    foa_vote_lane u_vote (
      .travel (s2_dist[g]),
      .total  (s2_total),
      .keep   (lane_keep[g])
    );
  end

  always_ff @(posedge clk) begin
    if (adv[3]) begin
      s3_dist  <= s2_dist;
      s3_total <= s2_total;
      s3_mask  <= lane_keep;
    end
  end

  // merge: sum and count of kept encoders, choice of subset average
  always_comb begin
    ksum_next = '0;
    kept_n    = '0;
    for (int i = 0; i < ENC_COUNT; i++) begin
      if (s3_mask[i]) begin
        ksum_next = ksum_next + SUM_W'(s3_dist[i]);
        kept_n    = kept_n + KEPT_N_W'(1);
      end
    end
    subset_next = (s3_total > SUBSET_TOTAL) &&
                  ((kept_n == SUBSET_MIN) || (kept_n == SUBSET_MAX));
    three_next  = kept_n == SUBSET_MAX;
  end

  always_ff @(posedge clk) begin
    if (adv[4]) begin
      s4_total  <= s3_total;
      s4_mask   <= s3_mask;
      s4_ksum   <= ksum_next;
      s4_subset <= subset_next;
      s4_three  <= three_next;
    end
  end

  // kept sum divided by three, top two digits
  assign num4 = DIV_W'(s4_ksum);

  foa_div3_stage #(.NDIG(STAGE_DIGITS)) u_div_a (
    .rem_in  (2'b00),
    .digits  (num4[DIV_W-1 -: PART_W]),
    .quo     (part_a.quo),
    .rem_out (part_a.rem)
  );

  always_ff @(posedge clk) begin
    if (adv[5]) begin
      s5_total  <= s4_total;
      s5_mask   <= s4_mask;
      s5_ksum   <= s4_ksum;
      s5_subset <= s4_subset;
      s5_three  <= s4_three;
      s5_q_hi   <= part_a.quo;
      s5_rem    <= part_a.rem;
    end
  end

  // middle two digits
  assign num5 = DIV_W'(s5_ksum);

  foa_div3_stage #(.NDIG(STAGE_DIGITS)) u_div_b (
    .rem_in  (s5_rem),
    .digits  (num5[DIV_W-PART_W-1 -: PART_W]),
    .quo     (part_b.quo),
    .rem_out (part_b.rem)
  );

  always_ff @(posedge clk) begin
    if (adv[6]) begin
      s6_total  <= s5_total;
      s6_mask   <= s5_mask;
      s6_ksum   <= s5_ksum;
      s6_subset <= s5_subset;
      s6_three  <= s5_three;
      s6_q_hi   <= s5_q_hi;
      s6_q_mid  <= part_b.quo;
      s6_rem    <= part_b.rem;
    end
  end

  // last digit, then floor(256*r/3) as the fraction byte
  foa_div3_stage #(.NDIG(1)) u_div_c (
    .rem_in  (s6_rem),
    .digits  (s6_ksum[DIG_W-1:0]),
    .quo     (quo_lo),
    .rem_out (rem_lo)
  );

  always_comb begin
    quo_all = {s6_q_hi, s6_q_mid, quo_lo};
    unique case (rem_lo)
      2'd1:    frac = 8'd85;
      2'd2:    frac = 8'd170;
      default: frac = 8'd0;
    endcase
    if (!s6_subset) begin
      avg_next = {s6_total, 6'b000000};
    end else if (!s6_three) begin
      avg_next = {s6_ksum[SUM_W-2:0], 7'b0000000};
    end else begin
      avg_next = {quo_all[QUO_W-1:0], frac};
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (adv[STAGES]) begin
      distance_avg_q8 <= avg_next;
      kept_mask       <= s6_mask;
      used_subset     <= s6_subset;
    end
  end

  // checks
  `FOA_ASSERT_IMP(a_subset_count, out_valid && used_subset, ($countones(kept_mask) == 2) || ($countones(kept_mask) == 3), "subset average with wrong kept count")
  `FOA_ASSERT_IMP(a_full_avg_lsbs, out_valid && !used_subset, distance_avg_q8[5:0] == 6'd0, "full average not a multiple of 64")
  `FOA_ASSERT_IMP(a_stall_full, in_stall, out_valid && out_stall && (&vld), "input stalled with room in pipeline")
  `FOA_ASSERT_NEXT(a_accept_fills, in_valid && !in_stall, vld[1], "accepted item lost at first stage")

endmodule

// ===== sim/four_encoder_outlier_average_unit_tb.sv =====
module four_encoder_outlier_average_unit_tb;
  import foa_pkg::*;

  // voting thresholds; the totals are in terms of the sum of the four distances
  localparam logic [DIST_W-1:0] LOW_MOVE       = 32'd10;
  localparam logic [SUM_W-1:0]  MOVING_TOTAL   = 34'd400;
  localparam logic [SUM_W-1:0]  FAST_TOTAL     = 34'd1200;
  localparam int                SETTLE_CYCLES  = 16;
  localparam int                WATCHDOG_LIMIT = 3000;
  localparam int                PRINT_LIMIT    = 40;

  localparam logic signed [63:0] POS_MAX = 64'sd2147483647;
  localparam logic signed [63:0] POS_MIN = -64'sd2147483648;
  localparam logic [DIST_W-1:0]  DIST_MAX = 32'hFFFF_FFFF;

  typedef logic [ENC_COUNT-1:0][POS_W-1:0] pos_set_t;

  typedef struct packed {
    logic [AVG_W-1:0] avg_q8;
    logic [3:0]       mask;
    logic             subset;
  } avg_result_t;

  typedef struct packed {
    logic [CFG_INDEX_W-1:0] index;
    logic [POS_W-1:0]       data;
  } reg_write_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   in_valid = 1'b0;
  logic                   in_stall;
  pos_t                   pos_front_left = '0;
  pos_t                   pos_front_right = '0;
  pos_t                   pos_rear_left = '0;
  pos_t                   pos_rear_right = '0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  logic [AVG_W-1:0]       distance_avg_q8;
  logic [3:0]             kept_mask;
  logic                   used_subset;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [POS_W-1:0]       cfg_data = '0;

  // testbench copy of the baselines, pending results and run state
  pos_t        baseline_model [ENC_COUNT];
  avg_result_t pending_averages [$];
  reg_write_t  write_plan [$];
  int          mismatch_count = 0;
  int          idle_cycles = 0;
  int          sink_hold_cycles = 0;
  bit          idle_off = 1'b0;
  bit          offering = 1'b0;

  four_encoder_outlier_average_unit uut (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .pos_front_left  (pos_front_left),
    .pos_front_right (pos_front_right),
    .pos_rear_left   (pos_rear_left),
    .pos_rear_right  (pos_rear_right),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .distance_avg_q8 (distance_avg_q8),
    .kept_mask       (kept_mask),
    .used_subset     (used_subset),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  always #10 clk = ~clk;

  // expected average and vote for one sample against the current baselines
  function automatic avg_result_t predict_average(input pos_set_t p);
    logic signed [POS_W:0] diff;
    logic [DIST_W-1:0]     span [ENC_COUNT];
    logic [SUM_W-1:0]      total;
    logic [SUM_W-1:0]      kept_sum;
    logic [VOTE_W-1:0]     d8;
    logic [63:0]           wide;
    bit                    reject;
    int                    kept_n;
    avg_result_t           r;
    total = '0;
    kept_sum = '0;
    kept_n = 0;
    r = '0;
    for (int i = 0; i < ENC_COUNT; i++) begin
      diff = $signed({p[i][POS_W-1], p[i]}) -
             $signed({baseline_model[i][POS_W-1], baseline_model[i]});
      span[i] = diff[POS_W] ? DIST_W'(-diff) : DIST_W'(diff);
      total = total + SUM_W'(span[i]);
    end
    for (int i = 0; i < ENC_COUNT; i++) begin
      d8 = VOTE_W'(span[i]) << 3;
      reject = (d8 < VOTE_W'(total)) || (d8 > VOTE_W'(total) * 3) ||
               (span[i] < LOW_MOVE && total > MOVING_TOTAL);
      if (!reject) begin
        r.mask[i] = 1'b1;
        kept_sum = kept_sum + SUM_W'(span[i]);
        kept_n++;
      end
    end
    r.avg_q8 = AVG_W'(total) << 6;
    // fast and two or three agree: average the survivors only
    if (total > FAST_TOTAL && kept_n >= 2 && kept_n <= 3) begin
      wide = (64'(kept_sum) << 8) / 64'(kept_n);
      r.avg_q8 = wide[AVG_W-1:0];
      r.subset = 1'b1;
    end
    return r;
  endfunction

  function automatic int draw_wait();
    if (idle_off) return 0;
    case ($urandom_range(0, 3))
      0: return $urandom_range(0, 19);
      1: return $urandom_range(0, 3);
      default: return 0;
    endcase
  endfunction

  // position that lies the given distance from encoder i's baseline
  function automatic pos_t place(input int i, input logic [63:0] span);
    logic signed [63:0] b;
    logic signed [63:0] up;
    logic signed [63:0] dn;
    b = baseline_model[i];
    up = b + $signed(span);
    dn = b - $signed(span);
    if (up > POS_MAX && dn < POS_MIN) return pos_t'(up);
    if (up > POS_MAX) return pos_t'(dn);
    if (dn < POS_MIN) return pos_t'(up);
    return $urandom_range(0, 1) ? pos_t'(up) : pos_t'(dn);
  endfunction

  function automatic pos_set_t from_distances(input logic [63:0] d0, d1, d2, d3);
    pos_set_t p;
    p[0] = place(0, d0);
    p[1] = place(1, d1);
    p[2] = place(2, d2);
    p[3] = place(3, d3);
    return p;
  endfunction

  function automatic logic [63:0] rand_magnitude(input int max_bits);
    int bits;
    bits = $urandom_range(0, max_bits);
    if (bits == 0) return 64'd0;
    return 64'($urandom) >> (32 - bits);
  endfunction

  // one sample from a mix of agreeing wheels, slipping wheels, ratio edges and noise
  function automatic pos_set_t random_sample();
    logic [63:0] base_d;
    logic [63:0] d [ENC_COUNT];
    logic [63:0] k;
    int          odd;
    int          kind;
    pos_set_t    p;
    kind = $urandom_range(0, 19);
    base_d = rand_magnitude(30);
    for (int i = 0; i < ENC_COUNT; i++)
      d[i] = base_d - (base_d >> 3) + 64'($urandom) % ((base_d >> 2) + 1);
    case (kind)
      0, 1, 2: begin
        // raw noise over the whole field range
        for (int i = 0; i < ENC_COUNT; i++) p[i] = $urandom;
        return p;
      end
      3, 4, 5, 6, 7, 8: begin
        // one or two slipping or stuck wheels
        odd = $urandom_range(0, 3);
        d[odd] = $urandom_range(0, 1) ? base_d * $urandom_range(2, 6) : base_d >> 3;
        if ($urandom_range(0, 1)) d[(odd + 2) % ENC_COUNT] = 64'($urandom_range(0, 12));
      end
      9, 10, 11: begin
        // distances on the 0.5 and 1.5 ratio edges
        k = 64'($urandom_range(1, 1 << $urandom_range(1, 28)));
        odd = $urandom_range(0, 3);
        for (int i = 0; i < ENC_COUNT; i++)
          d[(i + odd) % ENC_COUNT] = (i < 2) ? k : 3 * k;
        odd = $urandom_range(0, 3);
        case ($urandom_range(0, 2))
          0: d[odd] = d[odd] + 1;
          1: d[odd] = d[odd] - 1;
          default: ;
        endcase
      end
      12, 13: begin
        // one wheel moving 0 to 11, around the low-move limit, while the rest move
        d[$urandom_range(0, 3)] = 64'($urandom_range(0, 11));
      end
      default: ;
    endcase
    return from_distances(d[0], d[1], d[2], d[3]);
  endfunction

  // one input item; valid stays high after acceptance for back-to-back items
  task automatic send_item(input pos_set_t p);
    int gap;
    gap = draw_wait();
    if (gap > 0) begin
      if (offering) in_valid <= 1'b0;
      offering = 1'b0;
      repeat (gap) @(posedge clk);
    end
    if (!offering) in_valid <= 1'b1;
    offering = 1'b1;
    pos_front_left  <= p[0];
    pos_front_right <= p[1];
    pos_rear_left   <= p[2];
    pos_rear_right  <= p[3];
    do @(posedge clk); while (in_stall);
    pending_averages.push_back(predict_average(p));
  endtask

  task automatic wait_drained();
    if (offering) in_valid <= 1'b0;
    offering = 1'b0;
    while (pending_averages.size() != 0) @(posedge clk);
  endtask

  // runs the queued register writes once every result is in
  task automatic apply_writes();
    reg_write_t w;
    wait_drained();
    cfg_valid <= 1'b1;
    while (write_plan.size() != 0) begin
      w = write_plan.pop_front();
      cfg_index <= w.index;
      cfg_data  <= w.data;
      do @(posedge clk); while (!cfg_ready);
      if (w.index < ENC_COUNT) baseline_model[w.index] = w.data;
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic plan_baselines(input pos_set_t b);
    write_plan.push_back('{REG_BASE_FL, b[0]});
    write_plan.push_back('{REG_BASE_FR, b[1]});
    write_plan.push_back('{REG_BASE_RL, b[2]});
    write_plan.push_back('{REG_BASE_RR, b[3]});
  endtask

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    if (mismatch_count < PRINT_LIMIT)
      $display("mismatch %s: got %0d, expected %0d", what, got, want);
    mismatch_count++;
  endtask

  // result sink: random stalls, plus one long hold-off on request
  initial begin : result_sink
    int hold;
    forever begin
      if (sink_hold_cycles > 0) begin
        hold = sink_hold_cycles;
        sink_hold_cycles = 0;
      end else begin
        hold = draw_wait();
      end
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  // compare each accepted result with the oldest pending one
  always @(posedge clk) begin : result_check
    avg_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_averages.size() == 0) begin
        report_mismatch("unexpected result, avg", distance_avg_q8, 0);
      end else begin
        want = pending_averages.pop_front();
        if (distance_avg_q8 !== want.avg_q8)
          report_mismatch("distance_avg_q8", distance_avg_q8, want.avg_q8);
        if (kept_mask !== want.mask) report_mismatch("kept_mask", kept_mask, want.mask);
        if (used_subset !== want.subset)
          report_mismatch("used_subset", used_subset, want.subset);
      end
    end
  end

  // stop a hung run: too long without any handshake
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  // votes and subset average with the baselines left at reset
  task automatic test_reset_baselines();
    send_item(from_distances(0, 0, 0, 0));
    send_item({32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF});
    send_item({32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000});
    send_item({32'hFFFF_FFFF, 32'h0000_0000, 32'h8000_0000, 32'h7FFF_FFFF});
    send_item(from_distances(1000, 1000, 1000, 5000));
    send_item(from_distances(1001, 1000, 1000, 5000));
    send_item(from_distances(1000, 1000, 100, 3000));
    send_item(from_distances(0, 0, 0, 4000));
    send_item(from_distances(100, 100, 100, 500));
    send_item(from_distances(151, 151, 453, 453));
    send_item(from_distances(150, 151, 453, 453));
    send_item(from_distances(151, 151, 453, 454));
    send_item(from_distances(5, 300, 300, 300));
    send_item(from_distances(9, 131, 131, 130));
    send_item(from_distances(360, 360, 360, 120));
    send_item(from_distances(361, 360, 360, 120));
  endtask

  // widest distances, with baselines at opposite ends of the range
  task automatic test_extreme_baselines();
    plan_baselines({32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000});
    apply_writes();
    send_item({32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF});
    send_item(from_distances(DIST_MAX, DIST_MAX, DIST_MAX, 0));
    send_item(from_distances(DIST_MAX / 3, DIST_MAX / 3, DIST_MAX / 30, DIST_MAX));
    send_item(from_distances(DIST_MAX, DIST_MAX - 1, DIST_MAX / 2, DIST_MAX));
    send_item({32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000});
  endtask

  // writes outside the register range must leave the baselines alone
  task automatic test_ignored_index();
    plan_baselines({$urandom, $urandom, $urandom, $urandom});
    write_plan.push_back('{8'hFF, $urandom});
    write_plan.push_back('{8'd4, $urandom});
    write_plan.push_back('{8'h80, $urandom});
    write_plan.push_back('{8'($urandom_range(5, 255)), $urandom});
    apply_writes();
    for (int n = 0; n < 6; n++) send_item(random_sample());
  endtask

  // sink holds off for a long stretch while items keep coming
  task automatic test_back_pressure();
    wait_drained();
    idle_off = 1'b1;
    sink_hold_cycles = 300;
    for (int n = 0; n < 60; n++) send_item(random_sample());
    wait_drained();
    idle_off = 1'b0;
  endtask

  task automatic test_random_phase(input pos_set_t b, input int items, input int burst);
    plan_baselines(b);
    apply_writes();
    idle_off = 1'b1;
    for (int n = 0; n < items; n++) begin
      if (n == burst) idle_off = 1'b0;
      send_item(random_sample());
    end
    idle_off = 1'b0;
  endtask

  initial begin
    for (int i = 0; i < ENC_COUNT; i++) baseline_model[i] = '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_baselines();
    test_extreme_baselines();
    test_ignored_index();
    test_random_phase('0, 330, 0);
    test_random_phase({4{32'h8000_0000}}, 330, 40);
    test_back_pressure();
    test_random_phase({4{32'h7FFF_FFFF}}, 330, 0);
    test_random_phase({$urandom, $urandom, $urandom, $urandom}, 330, 60);
    test_random_phase({32'($urandom_range(0, 2000)) - 32'd1000, 32'd1, 32'hFFFF_FFFF,
                       32'($urandom_range(0, 2000)) - 32'd1000}, 330, 0);

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_averages.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
